// ----- sv/psg_three_voice_sound_generator_defines.svh -----
// Assertion macros for the three-voice sound generator.
// Included by the top level; defining NO_ASSERTIONS compiles them away.
`ifndef PSG_THREE_VOICE_SOUND_GENERATOR_DEFINES_SVH
`define PSG_THREE_VOICE_SOUND_GENERATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication checked on every clock edge outside reset.
`define PSG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psg assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define PSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psg assertion failed");
`else
`define PSG_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PSG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- sv/psg_pkg.sv -----
// Shared types, codes and the envelope shape table of the sound generator.
// No dependencies; used by every module.
package psg_pkg;

   // Operation codes carried by an input word.
   localparam logic [1:0] OpBusWrite = 2'd0;
   localparam logic [1:0] OpBusRead  = 2'd1;
   localparam logic [1:0] OpTick     = 2'd2;

   // Bus control codes (BDIR, BC2, BC1).
   localparam logic [2:0] BusLatchA  = 3'd1;
   localparam logic [2:0] BusLatchB  = 3'd4;
   localparam logic [2:0] BusLatchC  = 3'd7;
   localparam logic [2:0] BusWrite   = 3'd6;
   localparam logic [2:0] BusRead    = 3'd3;

   // Register file layout.
   localparam int RegCount = 16;
   localparam logic [3:0] RegToneAFine = 4'd0;
   localparam logic [3:0] RegToneACoarse = 4'd1;
   localparam logic [3:0] RegToneBFine = 4'd2;
   localparam logic [3:0] RegToneBCoarse = 4'd3;
   localparam logic [3:0] RegToneCFine = 4'd4;
   localparam logic [3:0] RegToneCCoarse = 4'd5;
   localparam logic [3:0] RegNoise   = 4'd6;
   localparam logic [3:0] RegMixer   = 4'd7;
   localparam logic [3:0] RegLevelA  = 4'd8;
   localparam logic [3:0] RegLevelB  = 4'd9;
   localparam logic [3:0] RegLevelC  = 4'd10;
   localparam logic [3:0] RegEnvLow  = 4'd11;
   localparam logic [3:0] RegEnvHigh = 4'd12;
   localparam logic [3:0] RegShape   = 4'd13;

   // Read data when the chip is enabled but the read code is absent.
   localparam logic [7:0] ReadIdle = 8'hff;

   // Envelope steps: three 32-step segments, looping back over the last two.
   localparam int EnvSegSteps = 32;
   localparam logic [6:0] EnvStepWrap = 7'(3 * EnvSegSteps);
   localparam logic [6:0] EnvStepBack = 7'(2 * EnvSegSteps);

   typedef enum logic [1:0] {
      SegZero = 2'd0,
      SegHold = 2'd1,
      SegRise = 2'd2,
      SegFall = 2'd3
   } psg_seg_type;

   typedef struct packed {
      logic [1:0] op;
      logic [2:0] bus_control;
      logic       chip_enable;
      logic [7:0] data;
   } psg_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] level_a;
      logic [7:0] level_b;
      logic [7:0] level_c;
   } psg_rsp_type;

   // Control from the top level to the envelope generator.
   typedef struct packed {
      logic tick;
      logic restart;
   } psg_env_ctl_type;

   // Segment kind for a shape and a segment number; segment 3 is silent.
   function automatic psg_seg_type psg_shape_seg(input logic [3:0] shape,
                                                  input logic [1:0] seg);
      psg_seg_type s0;
      psg_seg_type s1;
      psg_seg_type s2;
      psg_seg_type kind;
      s0 = SegFall;
      s1 = SegZero;
      s2 = SegZero;
      case (shape)
         4'd4, 4'd5, 4'd6, 4'd7, 4'd15: begin
            s0 = SegRise;
         end
         4'd8: begin
            s1 = SegFall;
            s2 = SegFall;
         end
         4'd10: begin
            s1 = SegRise;
            s2 = SegFall;
         end
         4'd11: begin
            s1 = SegHold;
            s2 = SegHold;
         end
         4'd12: begin
            s0 = SegRise;
            s1 = SegRise;
            s2 = SegRise;
         end
         4'd13: begin
            s0 = SegRise;
            s1 = SegHold;
            s2 = SegHold;
         end
         4'd14: begin
            s0 = SegRise;
            s1 = SegFall;
            s2 = SegRise;
         end
         default: begin
            s0 = SegFall;
         end
      endcase
      case (seg)
         2'd0: kind = s0;
         2'd1: kind = s1;
         2'd2: kind = s2;
         default: kind = SegZero;
      endcase
      return kind;
   endfunction

endpackage

// ----- sv/psg_chan_if.sv -----
// Valid/ready channel carrying one word per handshake.
// Word type is a parameter; the sound generator uses the types of psg_pkg.
interface psg_chan_if #(parameter type word_type = logic [7:0]);
   logic     valid;
   logic     ready;
   word_type word;

   modport source(output valid, output word, input ready);
   modport sink(input valid, input word, output ready);
endinterface

// ----- sv/psg_three_voice_sound_generator.sv -----
// Top level of the three-voice sound generator: bus register file, noise,
// mixer and result register. Depends on psg_pkg, psg_chan_if, psg_tone,
// psg_env and the assertion macros header.
//
// Use: every word on req_chan is one operation: a bus write (address latch
// or data write), a bus read, or one sample tick. A bus read gives one word
// on rsp_chan with read_data set and the levels zero; a tick gives one word
// with the three voice levels and read_data zero; a bus write and the unused
// op code give no word.
// A word accepted on req_chan is registered in the input register; its result
// is loaded into the result register when that register is free or being
// emptied, and rsp_chan.valid rises once the result register holds it.
// Throughput: one word per cycle unless rsp_chan stalls, set by the single
// input register feeding the single result register; all counters update in that step.
// Reset (synchronous, active high) clears the register file, the address
// pointer, all tone, noise and envelope counters and both stage valids.
// When rsp_chan is stalled with a word waiting, the result register holds
// its word, the input register holds the next word whatever its op, and
// req_chan.ready drops once the input register holds a word.
`include "psg_three_voice_sound_generator_defines.svh"

module psg_three_voice_sound_generator
   import psg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   psg_chan_if.sink      req_chan,
   psg_chan_if.source    rsp_chan
);

   // Input stage.
   logic        in_valid_ff;
   logic        in_valid_in;
   psg_req_type in_word_ff;
   psg_req_type in_word_in;

   // Result stage.
   logic        out_valid_ff;
   logic        out_valid_in;
   psg_rsp_type out_word_ff;
   psg_rsp_type out_word_in;

   // Architectural state.
   logic [7:0]  rf_ff [RegCount];
   logic [3:0]  ptr_ff;
   logic [3:0]  ptr_in;
   logic [5:0]  noise_count_ff;
   logic [5:0]  noise_count_in;
   logic [16:0] noise_shift_ff;
   logic [16:0] noise_shift_in;

   // Decode of the word in the input register.
   logic            advance;
   logic            has_result;
   logic            is_write;
   logic            is_read;
   logic            is_tick;
   logic            do_latch;
   logic            do_store;
   psg_env_ctl_type env_ctl;

   logic tone_a;
   logic tone_b;
   logic tone_c;
   logic noise_bit;
   logic [7:0] env_level;

   logic [4:0] noise_period;
   logic [5:0] noise_limit;
   logic [5:0] noise_phase;
   logic       noise_fb;
   logic [7:0] rd_byte;

   // A word moves on when the result register is free or being emptied.
   always_comb begin
      is_write   = (in_word_ff.op == OpBusWrite);
      is_read    = (in_word_ff.op == OpBusRead);
      is_tick    = (in_word_ff.op == OpTick);
      has_result = is_read || is_tick;
      advance    = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
      do_latch   = advance && is_write && in_word_ff.chip_enable &&
                   ((in_word_ff.bus_control == BusLatchA) ||
                    (in_word_ff.bus_control == BusLatchB) ||
                    (in_word_ff.bus_control == BusLatchC));
      do_store   = advance && is_write && in_word_ff.chip_enable &&
                   (in_word_ff.bus_control == BusWrite);
      env_ctl.tick    = advance && is_tick;
      env_ctl.restart = do_store && (ptr_ff == RegShape) &&
                        (rf_ff[RegShape] != in_word_ff.data);
   end

   assign req_chan.ready = !in_valid_ff || advance;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.word  = out_word_ff;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_word_in  = req_chan.word;
      end
   end

   // Address pointer: latches of 16 or more are ignored.
   always_comb begin
      ptr_in = ptr_ff;
      if (do_latch && (in_word_ff.data[7:4] == 4'd0)) begin
         ptr_in = in_word_ff.data[3:0];
      end
   end

   // Noise divider and 17-bit shift register; all-zero feeds back a one.
   always_comb begin
      noise_period   = (rf_ff[RegNoise][4:0] == 5'd0) ? 5'd1 : rf_ff[RegNoise][4:0];
      noise_limit    = {noise_period, 1'b0};
      noise_phase    = (noise_count_ff >= noise_limit) ? 6'd0 : noise_count_ff;
      noise_fb       = (noise_shift_ff == 17'd0) ^ noise_shift_ff[0] ^ noise_shift_ff[3];
      noise_bit      = noise_shift_ff[0];
      noise_shift_in = noise_shift_ff;
      noise_count_in = noise_count_ff;
      if (env_ctl.tick) begin
         if (noise_phase == 6'd0) begin
            noise_shift_in = {noise_fb, noise_shift_ff[16:1]};
         end
         noise_count_in = noise_phase + 6'd1;
      end
   end

   // Voice tone counters.
   psg_tone u_tone_a (
      .clock  (clock),
      .reset  (reset),
      .tick   (env_ctl.tick),
      .period ({rf_ff[RegToneACoarse][3:0], rf_ff[RegToneAFine]}),
      .tone   (tone_a)
   );

   psg_tone u_tone_b (
      .clock  (clock),
      .reset  (reset),
      .tick   (env_ctl.tick),
      .period ({rf_ff[RegToneBCoarse][3:0], rf_ff[RegToneBFine]}),
      .tone   (tone_b)
   );

   psg_tone u_tone_c (
      .clock  (clock),
      .reset  (reset),
      .tick   (env_ctl.tick),
      .period ({rf_ff[RegToneCCoarse][3:0], rf_ff[RegToneCFine]}),
      .tone   (tone_c)
   );

   // Envelope.
   psg_env u_env (
      .clock  (clock),
      .reset  (reset),
      .ctl    (env_ctl),
      .shape  (rf_ff[RegShape][3:0]),
      .period ({rf_ff[RegEnvHigh], rf_ff[RegEnvLow]}),
      .level  (env_level)
   );

   // Mixer gate and level selection for one voice.
   function automatic logic [7:0] voice_level(input logic tone_dis,
                                              input logic noise_dis,
                                              input logic tone,
                                              input logic noise,
                                              input logic [7:0] lvl_reg,
                                              input logic [7:0] env);
      logic [3:0] fixed;
      logic [7:0] lvl;
      fixed = lvl_reg[3:0];
      if (!((tone_dis || tone) && (noise_dis || noise))) begin
         lvl = 8'd0;
      end else if (lvl_reg[4]) begin
         lvl = env;
      end else begin
         lvl = {fixed, (fixed != 4'd0) ? 4'hf : 4'h0};
      end
      return lvl;
   endfunction

   // Result word for a read or a tick.
   always_comb begin
      if (!in_word_ff.chip_enable) begin
         rd_byte = 8'd0;
      end else if (in_word_ff.bus_control == BusRead) begin
         rd_byte = rf_ff[ptr_ff];
      end else begin
         rd_byte = ReadIdle;
      end
      out_word_in = '0;
      if (is_read) begin
         out_word_in.read_data = rd_byte;
      end else begin
         out_word_in.level_a = voice_level(rf_ff[RegMixer][0], rf_ff[RegMixer][3],
                                           tone_a, noise_bit, rf_ff[RegLevelA], env_level);
         out_word_in.level_b = voice_level(rf_ff[RegMixer][1], rf_ff[RegMixer][4],
                                           tone_b, noise_bit, rf_ff[RegLevelB], env_level);
         out_word_in.level_c = voice_level(rf_ff[RegMixer][2], rf_ff[RegMixer][5],
                                           tone_c, noise_bit, rf_ff[RegLevelC], env_level);
      end
      out_valid_in = advance ? has_result : (out_valid_ff && !rsp_chan.ready);
   end

   // Stage registers and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         ptr_ff         <= 4'd0;
         noise_count_ff <= 6'd0;
         noise_shift_ff <= 17'd0;
         for (int i = 0; i < RegCount; i++) begin
            rf_ff[i] <= 8'd0;
         end
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         ptr_ff         <= ptr_in;
         noise_count_ff <= noise_count_in;
         noise_shift_ff <= noise_shift_in;
         if (do_store) begin
            rf_ff[ptr_ff] <= in_word_ff.data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
      if (advance && has_result) begin
         out_word_ff <= out_word_in;
      end
   end

   // A blocked input word stays put.
   `PSG_ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !advance,
                    in_valid_ff && $stable(in_word_ff))
   // The pointer only moves when a word is processed.
   `PSG_ASSERT_NEXT(a_ptr_hold, clock, reset, !advance, $stable(ptr_ff))
   // A tick result never carries read data.
   `PSG_ASSERT_NEXT(a_tick_word, clock, reset, advance && is_tick,
                    out_valid_ff && (out_word_ff.read_data == 8'd0))
   // A read result never carries levels.
   `PSG_ASSERT_NEXT(a_read_word, clock, reset, advance && is_read,
                    out_valid_ff && (out_word_ff.level_a == 8'd0) &&
                    (out_word_ff.level_b == 8'd0) && (out_word_ff.level_c == 8'd0))

endmodule

// ----- sv/psg_tone.sv -----
// Square-wave tone counter for one voice.
// Depends on psg_pkg only for house consistency of types.
module psg_tone
   import psg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        tick,
   input  logic [11:0] period,
   output logic        tone
);

   logic [12:0] count_ff;
   logic [12:0] count_in;
   logic [11:0] period_eff;
   logic [12:0] limit;
   logic [13:0] count_inc;

   // A zero period behaves as one; the counter spans two half periods.
   always_comb begin
      period_eff = (period == 12'd0) ? 12'd1 : period;
      limit      = {period_eff, 1'b0};
      count_inc  = {1'b0, count_ff} + 14'd1;
      tone       = (count_ff >= {1'b0, period_eff});
      count_in   = (count_inc >= {1'b0, limit}) ? 13'd0 : count_inc[12:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 13'd0;
      end else if (tick) begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- sv/psg_env.sv -----
// Envelope generator: period divider, 96-step position and level lookup.
// Depends on psg_pkg for the shape table and the control struct.
module psg_env
   import psg_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  psg_env_ctl_type ctl,
   input  logic [3:0]      shape,
   input  logic [15:0]     period,
   output logic [7:0]      level
);

   logic [15:0] count_ff;
   logic [15:0] count_in;
   logic [6:0]  step_ff;
   logic [6:0]  step_in;
   logic [15:0] period_eff;
   logic [16:0] count_inc;
   logic [6:0]  step_inc;
   psg_seg_type kind;
   logic [4:0]  pos;
   logic [4:0]  amp;

   // Level of the current step under the current shape.
   always_comb begin
      pos  = step_ff[4:0];
      kind = psg_shape_seg(shape, step_ff[6:5]);
      case (kind)
         SegRise: amp = pos;
         SegFall: amp = 5'd31 - pos;
         SegHold: amp = 5'd31;
         default: amp = 5'd0;
      endcase
      level = {amp, (amp != 5'd0) ? 3'b111 : 3'b000};
   end

   // Divider and step advance; past the third segment the step loops back.
   always_comb begin
      period_eff = (period == 16'd0) ? 16'd1 : period;
      count_inc  = {1'b0, count_ff} + 17'd1;
      step_inc   = step_ff + 7'd1;
      count_in   = count_ff;
      step_in    = step_ff;
      if (ctl.restart) begin
         count_in = 16'd0;
         step_in  = 7'd0;
      end else if (ctl.tick) begin
         if (count_inc >= {1'b0, period_eff}) begin
            count_in = 16'd0;
            step_in  = (step_inc >= EnvStepWrap) ? step_inc - EnvStepBack : step_inc;
         end else begin
            count_in = count_inc[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 16'd0;
         step_ff  <= 7'd0;
      end else begin
         count_ff <= count_in;
         step_ff  <= step_in;
      end
   end

endmodule
